// ===== sv/scaf_pkg.sv =====
// scaf_pkg: shared types, constants and codes for the size-class allocator.
// Used by scaf_front, scaf_back and size_class_free_list_allocator.
// No dependencies.
package scaf_pkg;

	// Sizing of the allocator
	localparam int CLASS_COUNT = 4;
	localparam int TRAY_WORDS  = 512;
	localparam int WORD_BYTES  = 8;
	localparam int POOL_TRAYS  = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam int POOL_WORDS = POOL_TRAYS * TRAY_WORDS;
	localparam int SMALL_MAX  = CLASS_COUNT * WORD_BYTES;

	// Port widths fixed by the interface
	localparam int CMD_W  = 1;
	localparam int SIZE_W = 16;
	localparam int ADDR_W = 13;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 5;

	// Derived widths
	localparam int LINK_W  = $clog2(POOL_WORDS + 1);
	localparam int RAM_AW  = $clog2(POOL_WORDS);
	localparam int CLS_W   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
	localparam int SZ_W    = (SMALL_MAX > 1) ? $clog2(SMALL_MAX) : 1;
	localparam int TRAYS_W = $clog2(POOL_TRAYS + 1);
	localparam int QP_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W   = 8;

	// Null link: one past the last pool word
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_WORDS);

	localparam logic [CFG_W-1:0] TRAYS_ALLOWED_RST = CFG_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_SYSTEM    = 2'd1,
		STAT_EXHAUSTED = 2'd2
	} status_t;

	// Classified request handed from front to back
	typedef struct packed {
		cmd_t              cmd;
		logic              too_large;
		logic [CLS_W-1:0]  cls;
		logic [ADDR_W-1:0] addr;
	} req_t;

endpackage

// ===== sv/scaf_ram.sv =====
// scaf_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module scaf_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/scaf_front.sv =====
// scaf_front: accepts request transactions, sorts them into size classes and
// buffers them in a short queue for the back end. Depends on scaf_pkg.
module scaf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [scaf_pkg::CMD_W-1:0]     command,
	input  logic [scaf_pkg::SIZE_W-1:0]    size_bytes,
	input  logic [scaf_pkg::ADDR_W-1:0]    block_address,
	output logic                           q_valid,
	output scaf_pkg::req_t                 q_item,
	input  logic                           q_pop
);

	scaf_pkg::req_t                 req;
	logic [scaf_pkg::SZ_W-1:0]      sz_m1;
	logic                           push;

	scaf_pkg::req_t                 q_mem_q [scaf_pkg::QUEUE_DEPTH];
	logic [scaf_pkg::QP_W-1:0]      wr_ptr_q;
	logic [scaf_pkg::QP_W-1:0]      rd_ptr_q;
	logic [scaf_pkg::QC_W-1:0]      count_q;

	// class = (size-1)/word_bytes, size zero folds into class 0
	always_comb begin
		sz_m1 = (size_bytes == '0) ? '0 :
			scaf_pkg::SZ_W'(size_bytes - scaf_pkg::SIZE_W'(1));
		req.cmd       = scaf_pkg::cmd_t'(command);
		req.too_large = size_bytes > scaf_pkg::SIZE_W'(scaf_pkg::SMALL_MAX);
		req.cls       = scaf_pkg::CLS_W'(sz_m1 / scaf_pkg::WORD_BYTES);
		req.addr      = block_address;
	end

	assign in_stall = (count_q == scaf_pkg::QC_W'(scaf_pkg::QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_item   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == scaf_pkg::QP_W'(scaf_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + scaf_pkg::QP_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == scaf_pkg::QP_W'(scaf_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + scaf_pkg::QP_W'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + scaf_pkg::QC_W'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - scaf_pkg::QC_W'(1);
			end
		end
	end

endmodule

// ===== sv/scaf_back.sv =====
// scaf_back: executes classified requests - list push/pop, tray carving - and
// holds the result register. Depends on scaf_pkg and scaf_ram (link memory).
module scaf_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  scaf_pkg::req_t                 q_item,
	output logic                           q_pop,
	input  logic [scaf_pkg::CFG_W-1:0]     trays_allowed,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [scaf_pkg::ADDR_W-1:0]    result_address,
	output logic [scaf_pkg::STAT_W-1:0]    status
);

	typedef enum logic [1:0] {
		BK_RUN = 2'b01,
		BK_POP = 2'b10
	} bk_state_t;

	bk_state_t                        state_q;

	logic [scaf_pkg::LINK_W-1:0]      head_q      [scaf_pkg::CLASS_COUNT];
	logic [scaf_pkg::LINK_W-1:0]      carve_nxt_q [scaf_pkg::CLASS_COUNT];
	logic [scaf_pkg::ADDR_W-1:0]      carve_end_q [scaf_pkg::CLASS_COUNT];
	logic [scaf_pkg::TRAYS_W-1:0]     trays_used_q;
	logic [scaf_pkg::CLS_W-1:0]       pop_cls_q;
	logic [scaf_pkg::LINK_W-1:0]      pop_addr_q;

	logic                             out_valid_q;
	logic [scaf_pkg::ADDR_W-1:0]      out_addr_q;
	scaf_pkg::status_t                out_stat_q;

	logic [scaf_pkg::LINK_W-1:0]      carve_off [scaf_pkg::CLASS_COUNT];

	logic                             slot_free;
	logic [scaf_pkg::CLS_W-1:0]       t;
	logic [scaf_pkg::LINK_W-1:0]      n;
	logic [scaf_pkg::LINK_W-1:0]      head_t;
	logic [scaf_pkg::LINK_W-1:0]      cn_t;
	logic                             head_ok;
	logic                             cn_ok;
	logic                             addr_ok;
	logic                             exhausted;
	logic [scaf_pkg::LINK_W-1:0]      base;
	logic [scaf_pkg::LINK_W-1:0]      end_v;
	logic [scaf_pkg::LINK_W-1:0]      res;
	logic [scaf_pkg::LINK_W-1:0]      nxt;

	logic                             ram_we;
	logic                             ram_re;
	logic [scaf_pkg::LINK_W-1:0]      ram_rdata;

	// Offset of the last block in a tray of class c
	for (genvar c = 0; c < scaf_pkg::CLASS_COUNT; c++) begin : g_off
		localparam int OFF_C = (scaf_pkg::TRAY_WORDS / (c + 1) - 1) * (c + 1);
		assign carve_off[c] = scaf_pkg::LINK_W'(OFF_C);
	end

	assign slot_free = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == BK_RUN) && q_valid && slot_free;

	always_comb begin
		t       = q_item.cls;
		n       = scaf_pkg::LINK_W'(t) + scaf_pkg::LINK_W'(1);
		head_t  = head_q[t];
		cn_t    = carve_nxt_q[t];
		head_ok = head_t < scaf_pkg::NULL_LINK;
		cn_ok   = cn_t < scaf_pkg::NULL_LINK;
		addr_ok = scaf_pkg::LINK_W'(q_item.addr) < scaf_pkg::NULL_LINK;
		exhausted = (scaf_pkg::CMP_W'(trays_used_q) >= scaf_pkg::CMP_W'(trays_allowed)) ||
			(scaf_pkg::CMP_W'(trays_used_q) >= scaf_pkg::CMP_W'(scaf_pkg::POOL_TRAYS));
		base  = scaf_pkg::LINK_W'(trays_used_q) * scaf_pkg::LINK_W'(scaf_pkg::TRAY_WORDS);
		end_v = cn_ok ? scaf_pkg::LINK_W'(carve_end_q[t]) : base + carve_off[t];
		res   = cn_ok ? cn_t : base;
		nxt   = res + n;
	end

	assign ram_we = q_pop && !q_item.too_large && (q_item.cmd == scaf_pkg::CMD_FREE) &&
		addr_ok;
	assign ram_re = q_pop && !q_item.too_large && (q_item.cmd == scaf_pkg::CMD_ALLOC) &&
		head_ok;

	// Link memory: one next-pointer per pool word
	scaf_ram #(
		.WIDTH(scaf_pkg::LINK_W),
		.DEPTH(scaf_pkg::POOL_WORDS)
	) u_link (
		.clk   (clk),
		.we    (ram_we),
		.waddr (scaf_pkg::RAM_AW'(q_item.addr)),
		.wdata (head_t),
		.re    (ram_re),
		.raddr (scaf_pkg::RAM_AW'(head_t)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pop_cls_q  <= t;
			pop_addr_q <= head_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_RUN;
			trays_used_q <= '0;
			out_valid_q  <= 1'b0;
			out_addr_q   <= '0;
			out_stat_q   <= scaf_pkg::STAT_OK;
			for (int c = 0; c < scaf_pkg::CLASS_COUNT; c++) begin
				head_q[c]      <= scaf_pkg::NULL_LINK;
				carve_nxt_q[c] <= scaf_pkg::NULL_LINK;
				carve_end_q[c] <= '0;
			end
		end else begin
			case (state_q)
				BK_RUN: begin
					if (q_pop) begin
						if (q_item.too_large) begin
							out_valid_q <= 1'b1;
							out_addr_q  <= '0;
							out_stat_q  <= scaf_pkg::STAT_SYSTEM;
						end else if (q_item.cmd == scaf_pkg::CMD_FREE) begin
							out_valid_q <= 1'b1;
							out_addr_q  <= '0;
							out_stat_q  <= scaf_pkg::STAT_OK;
							if (addr_ok) begin
								head_q[t] <= scaf_pkg::LINK_W'(q_item.addr);
							end
						end else if (head_ok) begin
							// result comes after the link read
							out_valid_q <= 1'b0;
							state_q     <= BK_POP;
						end else if (!cn_ok && exhausted) begin
							out_valid_q <= 1'b1;
							out_addr_q  <= '0;
							out_stat_q  <= scaf_pkg::STAT_EXHAUSTED;
						end else begin
							if (!cn_ok) begin
								trays_used_q   <= trays_used_q + scaf_pkg::TRAYS_W'(1);
								carve_end_q[t] <= scaf_pkg::ADDR_W'(end_v);
							end
							carve_nxt_q[t] <= (nxt <= end_v) ? nxt : scaf_pkg::NULL_LINK;
							out_valid_q    <= 1'b1;
							out_addr_q     <= scaf_pkg::ADDR_W'(res);
							out_stat_q     <= scaf_pkg::STAT_OK;
						end
					end else if (!out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				BK_POP: begin
					if (slot_free) begin
						head_q[pop_cls_q] <= ram_rdata;
						out_valid_q       <= 1'b1;
						out_addr_q        <= scaf_pkg::ADDR_W'(pop_addr_q);
						out_stat_q        <= scaf_pkg::STAT_OK;
						state_q           <= BK_RUN;
					end else if (!out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= BK_RUN;
					if (!out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_stat_q;

endmodule

// ===== sv/size_class_free_list_allocator.sv =====
// size_class_free_list_allocator: top level of the segregated free-list allocator.
// Depends on scaf_pkg, scaf_front, scaf_back (which holds the scaf_ram link memory).
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------------
//   request  | in        | in_valid / in_stall   | command, size_bytes, block_address
//   result   | out       | out_valid / out_stall | result_address, status
//   config   | in        | cfg_wr_en (no wait)   | cfg_wr_data -> trays_allowed
//
// Execution: a free, an oversize request, a tray carve or an exhausted allocate is
// done in the back end's run state; an allocate that pops a free list also passes
// through the pop state, for the registered link read (head -> link of that block).
// Reset: asynchronous, active low; all list heads and carve pointers go null,
// trays_used goes to 0, trays_allowed to 16. The link memory is not cleared.
// Stalls: a 2-entry queue separates request intake from execution; the result
// register holds a transaction until out_stall is low, and the back end keeps
// working into a freed slot in the same cycle.
module size_class_free_list_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [scaf_pkg::CMD_W-1:0]     command,
	input  logic [scaf_pkg::SIZE_W-1:0]    size_bytes,
	input  logic [scaf_pkg::ADDR_W-1:0]    block_address,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [scaf_pkg::ADDR_W-1:0]    result_address,
	output logic [scaf_pkg::STAT_W-1:0]    status,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [scaf_pkg::CFG_W-1:0]     cfg_wr_data
);

	logic                           q_valid;
	scaf_pkg::req_t                 q_item;
	logic                           q_pop;
	logic [scaf_pkg::CFG_W-1:0]     trays_allowed_q;

	// Tray limit register; values above the pool size are capped in the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trays_allowed_q <= scaf_pkg::TRAYS_ALLOWED_RST;
		end else if (cfg_wr_en) begin
			trays_allowed_q <= cfg_wr_data;
		end
	end

	// Front: intake, size classification, request queue
	scaf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.size_bytes    (size_bytes),
		.block_address (block_address),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	// Back: free lists, tray carving, link memory, result register
	scaf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop),
		.trays_allowed  (trays_allowed_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_address (result_address),
		.status         (status)
	);

endmodule
